/* src/wps_pkg.sv */
`default_nettype none

package wps_pkg;

	localparam int IDX_W = 3;
	localparam int COUNT_W = 4;
	localparam int LOSS_W = 20;
	localparam int RTT_W = 24;
	localparam int SCORE_W = 25;
	localparam int QUOT_W = 14;

	localparam logic [LOSS_W-1:0] LOSS_CAP = 20'd1000000;
	localparam logic [LOSS_W-1:0] VOICE_LOSS_LIMIT = 20'd1000;

	// Division by 100 as a multiplication by a reciprocal, exact for values below 1864135.
	localparam int RECIP_W = 21;
	localparam logic [RECIP_W-1:0] LOSS_RECIP = 21'd1342178;
	localparam int RECIP_SHIFT = 27;
	localparam int PROD_W = LOSS_W + RECIP_W;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic capture;
		logic write_entry;
		logic scan_step;
	} dp_ctrl_t;

	typedef struct packed {
		logic scan_done;
	} dp_status_t;

endpackage

`default_nettype wire

/* src/wps_datapath.sv */
`default_nettype none

module wps_datapath #(
	parameter int MAX_CIRCUITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wps_pkg::dp_ctrl_t             ctrl,
	output wps_pkg::dp_status_t                status,
	input  wire logic                          cfg_we,
	input  wire logic [wps_pkg::COUNT_W-1:0]   cfg_data,
	input  wire logic [wps_pkg::IDX_W-1:0]     circuit_index,
	input  wire logic                          circuit_up,
	input  wire logic [wps_pkg::LOSS_W-1:0]    loss_rate,
	input  wire logic [wps_pkg::RTT_W-1:0]     rtt_us,
	input  wire logic                          is_voice,
	output logic [wps_pkg::IDX_W-1:0]          path_index,
	output logic                               fallback
);

	localparam int IW = $clog2(MAX_CIRCUITS);
	localparam int CW = $clog2(MAX_CIRCUITS + 1);

	logic [wps_pkg::COUNT_W-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] k_q;
	logic found_q;
	logic [IW-1:0] best_idx_q;
	logic [wps_pkg::LOSS_W-1:0] best_loss_q;
	logic [wps_pkg::RTT_W-1:0] best_rtt_q;
	logic [wps_pkg::SCORE_W-1:0] best_score_q;

	logic [wps_pkg::IDX_W-1:0] idx_q;
	logic up_q;
	logic [wps_pkg::LOSS_W-1:0] loss_q;
	logic [wps_pkg::RTT_W-1:0] rtt_q;
	logic voice_q;

	logic [MAX_CIRCUITS-1:0] active_q;
	logic [wps_pkg::LOSS_W-1:0] loss_tab_q [MAX_CIRCUITS];
	logic [wps_pkg::RTT_W-1:0] rtt_tab_q [MAX_CIRCUITS];
	logic [wps_pkg::SCORE_W-1:0] score_tab_q [MAX_CIRCUITS];

	logic [CW-1:0] n_clamped;
	logic [wps_pkg::LOSS_W-1:0] loss_capped;
	logic [wps_pkg::PROD_W-1:0] loss_prod;
	logic [wps_pkg::QUOT_W-1:0] loss_quot;
	logic [wps_pkg::SCORE_W-1:0] new_score;
	logic idx_in_range;
	logic [IW-1:0] wr_entry;
	logic [IW-1:0] rd_entry;
	logic cand_active;
	logic [wps_pkg::LOSS_W-1:0] cand_loss;
	logic [wps_pkg::RTT_W-1:0] cand_rtt;
	logic [wps_pkg::SCORE_W-1:0] cand_score;
	logic better;
	logic adopt;
	logic [31:0] best_idx_wide;

	always_comb begin
		if (32'(count_q) > MAX_CIRCUITS) begin
			n_clamped = CW'(MAX_CIRCUITS);
		end else begin
			n_clamped = CW'(count_q);
		end
		if (loss_rate > wps_pkg::LOSS_CAP) begin
			loss_capped = wps_pkg::LOSS_CAP;
		end else begin
			loss_capped = loss_rate;
		end
	end

	assign loss_prod = wps_pkg::PROD_W'(loss_q) * wps_pkg::PROD_W'(wps_pkg::LOSS_RECIP);
	assign loss_quot = wps_pkg::QUOT_W'(loss_prod >> wps_pkg::RECIP_SHIFT);
	assign new_score = wps_pkg::SCORE_W'(rtt_q) + wps_pkg::SCORE_W'(loss_quot);
	assign idx_in_range = 32'(idx_q) < MAX_CIRCUITS;
	assign wr_entry = IW'(32'(idx_q));

	assign rd_entry = k_q[IW-1:0];
	assign cand_active = active_q[rd_entry];
	assign cand_loss = loss_tab_q[rd_entry];
	assign cand_rtt = rtt_tab_q[rd_entry];
	assign cand_score = score_tab_q[rd_entry];

	always_comb begin
		if (voice_q) begin
			better = (cand_loss < wps_pkg::VOICE_LOSS_LIMIT) &&
				((best_loss_q >= wps_pkg::VOICE_LOSS_LIMIT) || (cand_rtt < best_rtt_q));
		end else begin
			better = cand_score < best_score_q;
		end
		adopt = ctrl.scan_step && cand_active && (!found_q || better);
	end

	assign status.scan_done = k_q >= n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q <= '0;
			k_q <= '0;
			found_q <= 1'b0;
			best_idx_q <= '0;
			active_q <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (ctrl.capture) begin
				n_q <= n_clamped;
				k_q <= '0;
				found_q <= 1'b0;
				best_idx_q <= '0;
			end else if (ctrl.scan_step) begin
				k_q <= k_q + CW'(1);
				if (adopt) begin
					found_q <= 1'b1;
					best_idx_q <= rd_entry;
				end
			end
			if (ctrl.write_entry && idx_in_range) begin
				active_q[wr_entry] <= up_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			idx_q <= circuit_index;
			up_q <= circuit_up;
			loss_q <= loss_capped;
			rtt_q <= rtt_us;
			voice_q <= is_voice;
		end
		if (adopt) begin
			best_loss_q <= cand_loss;
			best_rtt_q <= cand_rtt;
			best_score_q <= cand_score;
		end
		if (ctrl.write_entry && idx_in_range) begin
			loss_tab_q[wr_entry] <= loss_q;
			rtt_tab_q[wr_entry] <= rtt_q;
			score_tab_q[wr_entry] <= new_score;
		end
	end

	assign best_idx_wide = 32'(best_idx_q);
	assign path_index = best_idx_wide[wps_pkg::IDX_W-1:0];
	assign fallback = !found_q;

endmodule

`default_nettype wire

/* src/wps_controller.sv */
`default_nettype none

module wps_controller (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 cmd,
	input  wire wps_pkg::dp_status_t  status,
	output wps_pkg::dp_ctrl_t         ctrl,
	output logic                      busy,
	output logic                      done
);

	wps_pkg::state_t state_q;
	wps_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wps_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		ctrl = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			wps_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.capture = 1'b1;
					if (cmd == wps_pkg::CMD_UPDATE) begin
						state_next = wps_pkg::ST_WRITE;
					end else begin
						state_next = wps_pkg::ST_SCAN;
					end
				end
			end
			wps_pkg::ST_WRITE: begin
				ctrl.write_entry = 1'b1;
				state_next = wps_pkg::ST_IDLE;
			end
			wps_pkg::ST_SCAN: begin
				if (status.scan_done) begin
					state_next = wps_pkg::ST_REPORT;
				end else begin
					ctrl.scan_step = 1'b1;
				end
			end
			wps_pkg::ST_REPORT: begin
				done = 1'b1;
				state_next = wps_pkg::ST_IDLE;
			end
			default: begin
				state_next = wps_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/wan_path_selector.sv */
// Channel   Handshake             Payload
// command   start / busy          cmd, circuit_index, circuit_up, loss_rate, rtt_us, is_voice
// result    done (one cycle)      path_index, fallback
// config    cfg_we                cfg_data (circuit_count)
//
// An update transaction keeps busy high for one cycle while the circuit entry is written.
// A select transaction stays busy while it scans n entries, where n is the configured circuit
// count limited to MAX_CIRCUITS: one table entry per cycle is compared with the best so far.
// The result is shown with done in the last busy cycle; the receiver cannot stall it.
// Reset clears the circuit count and marks every circuit inactive.
`default_nettype none

module wan_path_selector #(
	parameter int MAX_CIRCUITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          cmd,
	input  wire logic [wps_pkg::IDX_W-1:0]     circuit_index,
	input  wire logic                          circuit_up,
	input  wire logic [wps_pkg::LOSS_W-1:0]    loss_rate,
	input  wire logic [wps_pkg::RTT_W-1:0]     rtt_us,
	input  wire logic                          is_voice,
	output logic                               done,
	output logic [wps_pkg::IDX_W-1:0]          path_index,
	output logic                               fallback,
	input  wire logic                          cfg_we,
	input  wire logic [wps_pkg::COUNT_W-1:0]   cfg_data
);

	wps_pkg::dp_ctrl_t ctrl;
	wps_pkg::dp_status_t status;

	wps_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	wps_datapath #(
		.MAX_CIRCUITS(MAX_CIRCUITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.circuit_index (circuit_index),
		.circuit_up    (circuit_up),
		.loss_rate     (loss_rate),
		.rtt_us        (rtt_us),
		.is_voice      (is_voice),
		.path_index    (path_index),
		.fallback      (fallback)
	);

endmodule

`default_nettype wire

/* src/wps_checker.sv */
`default_nettype none

module wps_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          cmd,
	input wire logic                          done,
	input wire logic [wps_pkg::IDX_W-1:0]     path_index,
	input wire logic                          fallback
);

	// A result appears only inside a transaction.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("Result strobe outside a transaction.");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_fallback_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fallback) |-> (path_index == '0))
		else $error("Fallback result does not select path zero.");

	// An update transaction is busy for one cycle and gives no result.
	a_update_len: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == wps_pkg::CMD_UPDATE) |=> (busy && !done) ##1 !busy)
		else $error("Update transaction did not finish in one cycle.");

	a_select_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == wps_pkg::CMD_SELECT) |=> (busy && !done))
		else $error("Select transaction did not start scanning.");

endmodule

bind wan_path_selector wps_checker u_wps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cmd        (cmd),
	.done       (done),
	.path_index (path_index),
	.fallback   (fallback)
);

`default_nettype wire
